// ===== hdl/tst_pkg.sv =====
`timescale 1ns / 1ps

package tst_pkg;

   localparam int SESSIONS_DEFAULT = 1024;
   localparam int TICKS_PER_SECOND_DEFAULT = 100;

   localparam int INDEX_W = 10;
   localparam int TICKS_W = 32;
   localparam int TIMEOUT_W = 16;
   localparam int STATE_W = 3;
   localparam int ENTRY_W = STATE_W + TICKS_W;

   localparam logic [TIMEOUT_W-1:0] EST_TIMEOUT_RESET = 16'd7440;
   localparam logic [TIMEOUT_W-1:0] TRANS_TIMEOUT_RESET = 16'd240;

   typedef enum logic [2:0] {
      ST_CLOSED   = 3'd0,
      ST_V6_SYN   = 3'd1,
      ST_V4_SYN   = 3'd2,
      ST_FOUR_MIN = 3'd3,
      ST_EST      = 3'd4,
      ST_V6_FIN   = 3'd5,
      ST_V4_FIN   = 3'd6,
      ST_BOTH_FIN = 3'd7
   } tcp_state_type;

   typedef enum logic [1:0] {
      CMD_CREATE  = 2'd0,
      CMD_V4_PKT  = 2'd1,
      CMD_V6_PKT  = 2'd2,
      CMD_TIMEOUT = 2'd3
   } command_type;

   typedef enum logic {
      CLS_EST   = 1'b0,
      CLS_TRANS = 1'b1
   } timer_class_type;

   typedef enum logic {
      REG_EST_TIMEOUT   = 1'b0,
      REG_TRANS_TIMEOUT = 1'b1
   } csr_index_type;

   typedef struct packed {
      tcp_state_type   next_state;
      logic            renew;
      timer_class_type renew_class;
      logic            kept;
   } transition_type;

endpackage

// ===== hdl/tst_session_mem.sv =====
`timescale 1ns / 1ps

module tst_session_mem #(
   parameter int DEPTH = tst_pkg::SESSIONS_DEFAULT,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [ADDR_W-1:0]            rd_addr,
   output logic [tst_pkg::ENTRY_W-1:0]  rd_data,
   input  logic                         wr_en,
   input  logic [ADDR_W-1:0]            wr_addr,
   input  logic [tst_pkg::ENTRY_W-1:0]  wr_data
);

   logic [tst_pkg::ENTRY_W-1:0] mem [DEPTH];
   logic [tst_pkg::ENTRY_W-1:0] rd_data_ff;

   // read returns the old word when the same entry is written at that edge
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/tst_transition.sv =====
`timescale 1ns / 1ps

module tst_transition (
   input  tst_pkg::command_type     command,
   input  tst_pkg::tcp_state_type   cur_state,
   input  logic                     syn_flag,
   input  logic                     fin_flag,
   input  logic                     rst_flag,
   input  tst_pkg::timer_class_type timer_class,
   output tst_pkg::transition_type  result
);

   always_comb begin
      result.next_state  = cur_state;
      result.renew       = 1'b0;
      result.renew_class = tst_pkg::CLS_EST;
      result.kept        = 1'b0;
      case (command)
         tst_pkg::CMD_CREATE: begin
            result.next_state  = tst_pkg::ST_CLOSED;
            result.renew       = 1'b1;
            result.renew_class = timer_class;
         end
         tst_pkg::CMD_V4_PKT, tst_pkg::CMD_V6_PKT: begin
            case (cur_state)
               tst_pkg::ST_CLOSED: begin
                  if (command == tst_pkg::CMD_V6_PKT && syn_flag) begin
                     result.next_state  = tst_pkg::ST_V6_SYN;
                     result.renew       = 1'b1;
                     result.renew_class = tst_pkg::CLS_TRANS;
                  end
               end
               tst_pkg::ST_V6_SYN: begin
                  if (syn_flag) begin
                     result.renew = 1'b1;
                     if (command == tst_pkg::CMD_V4_PKT) begin
                        result.next_state = tst_pkg::ST_EST;
                     end else begin
                        result.renew_class = tst_pkg::CLS_TRANS;
                     end
                  end
               end
               tst_pkg::ST_V4_SYN: begin
                  if (command == tst_pkg::CMD_V6_PKT && syn_flag) begin
                     result.next_state = tst_pkg::ST_EST;
                     result.renew      = 1'b1;
                  end
               end
               tst_pkg::ST_FOUR_MIN: begin
                  if (!rst_flag) begin
                     result.next_state = tst_pkg::ST_EST;
                     result.renew      = 1'b1;
                  end
               end
               tst_pkg::ST_EST: begin
                  if (fin_flag) begin
                     result.next_state = (command == tst_pkg::CMD_V4_PKT) ?
                                         tst_pkg::ST_V4_FIN : tst_pkg::ST_V6_FIN;
                  end else if (rst_flag) begin
                     result.next_state  = tst_pkg::ST_FOUR_MIN;
                     result.renew       = 1'b1;
                     result.renew_class = tst_pkg::CLS_TRANS;
                  end else begin
                     result.renew = 1'b1;
                  end
               end
               tst_pkg::ST_V6_FIN, tst_pkg::ST_V4_FIN: begin
                  result.renew = 1'b1;
                  // FIN from the side that has not yet closed
                  if (fin_flag &&
                      ((cur_state == tst_pkg::ST_V6_FIN && command == tst_pkg::CMD_V4_PKT) ||
                       (cur_state == tst_pkg::ST_V4_FIN && command == tst_pkg::CMD_V6_PKT)))
                  begin
                     result.next_state  = tst_pkg::ST_BOTH_FIN;
                     result.renew_class = tst_pkg::CLS_TRANS;
                  end
               end
               default: begin
                  result.next_state = cur_state;
               end
            endcase
         end
         tst_pkg::CMD_TIMEOUT: begin
            if (cur_state == tst_pkg::ST_EST) begin
               result.next_state  = tst_pkg::ST_FOUR_MIN;
               result.renew       = 1'b1;
               result.renew_class = tst_pkg::CLS_TRANS;
               result.kept        = 1'b1;
            end
         end
         default: begin
            result.next_state = cur_state;
         end
      endcase
   end

endmodule

// ===== hdl/tcp_session_state_tracker.sv =====
`timescale 1ns / 1ps

// channel   | handshake              | payload
// ----------+------------------------+---------------------------------------------
// request   | start, busy            | req_command, req_session_index, req_*_flag,
//           |                        | req_timer_class, req_now_ticks
// response  | rsp_strobe (one cycle) | rsp_new_state, rsp_renewed, rsp_renew_class,
//           |                        | rsp_deadline, rsp_kept
// csr       | csr_write_enable       | csr_index, csr_write_data
//
// One request per cycle while busy is low; the response strobe is registered in
// s1_valid_ff, then rsp_strobe_ff. The accepting edge issues the synchronous session read;
// the next cycle applies the transition, writes the entry back and registers the
// response. A write-back register forwards to a request for the same session that
// directly follows. busy is high during reset and until reset is sampled low, then
// stays low. Responses cannot be stalled; table entries are undefined until created.

module tcp_session_state_tracker #(
   parameter int SESSIONS = tst_pkg::SESSIONS_DEFAULT,
   parameter int TICKS_PER_SECOND = tst_pkg::TICKS_PER_SECOND_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_command,
   input  logic [tst_pkg::INDEX_W-1:0]       req_session_index,
   input  logic                              req_syn_flag,
   input  logic                              req_fin_flag,
   input  logic                              req_rst_flag,
   input  logic                              req_timer_class,
   input  logic [tst_pkg::TICKS_W-1:0]       req_now_ticks,
   output logic                              rsp_strobe,
   output logic [tst_pkg::STATE_W-1:0]       rsp_new_state,
   output logic                              rsp_renewed,
   output logic                              rsp_renew_class,
   output logic [tst_pkg::TICKS_W-1:0]       rsp_deadline,
   output logic                              rsp_kept,
   input  logic                              csr_write_enable,
   input  logic                              csr_index,
   input  logic [tst_pkg::TIMEOUT_W-1:0]     csr_write_data
);

   localparam int ADDR_W = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
   localparam int EXT_W = ((ADDR_W > tst_pkg::INDEX_W) ? ADDR_W : tst_pkg::INDEX_W) + 1;
   localparam logic [tst_pkg::TICKS_W-1:0] TPS = tst_pkg::TICKS_W'(TICKS_PER_SECOND);

   logic                          busy_ff;
   logic                          accept;
   logic [EXT_W-1:0]              idx_ext;
   logic                          idx_in_range;

   // timeouts are held already scaled to ticks
   logic [tst_pkg::TICKS_W-1:0]   est_ticks_ff;
   logic [tst_pkg::TICKS_W-1:0]   trans_ticks_ff;
   logic [tst_pkg::TICKS_W-1:0]   csr_ticks;

   logic                          s1_valid_ff;
   logic                          s1_in_range_ff;
   logic [ADDR_W-1:0]             s1_addr_ff;
   tst_pkg::command_type          s1_command_ff;
   logic                          s1_syn_ff;
   logic                          s1_fin_ff;
   logic                          s1_rst_ff;
   tst_pkg::timer_class_type      s1_class_ff;
   logic [tst_pkg::TICKS_W-1:0]   s1_now_ff;

   logic                          wb_valid_ff;
   logic [ADDR_W-1:0]             wb_addr_ff;
   logic [tst_pkg::ENTRY_W-1:0]   wb_data_ff;

   logic [tst_pkg::ENTRY_W-1:0]   rd_data;
   logic [tst_pkg::ENTRY_W-1:0]   cur_entry;
   tst_pkg::tcp_state_type        cur_state;
   tst_pkg::transition_type       trans;
   logic [tst_pkg::TICKS_W-1:0]   new_deadline;
   logic                          wr_en;
   logic [tst_pkg::ENTRY_W-1:0]   wr_data;

   logic                          rsp_strobe_ff;
   logic [tst_pkg::STATE_W-1:0]   rsp_state_ff;
   logic                          rsp_renewed_ff;
   logic                          rsp_class_ff;
   logic [tst_pkg::TICKS_W-1:0]   rsp_deadline_ff;
   logic                          rsp_kept_ff;

   assign accept       = start && !busy_ff;
   assign busy         = busy_ff;
   assign idx_ext      = EXT_W'(req_session_index);
   assign idx_in_range = idx_ext < EXT_W'(SESSIONS);
   assign csr_ticks    = tst_pkg::TICKS_W'(csr_write_data) * TPS;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b1;
         est_ticks_ff   <= tst_pkg::TICKS_W'(tst_pkg::EST_TIMEOUT_RESET) * TPS;
         trans_ticks_ff <= tst_pkg::TICKS_W'(tst_pkg::TRANS_TIMEOUT_RESET) * TPS;
      end else begin
         busy_ff <= 1'b0;
         if (csr_write_enable) begin
            case (tst_pkg::csr_index_type'(csr_index))
               tst_pkg::REG_EST_TIMEOUT:   est_ticks_ff   <= csr_ticks;
               tst_pkg::REG_TRANS_TIMEOUT: trans_ticks_ff <= csr_ticks;
               default:                    est_ticks_ff   <= est_ticks_ff;
            endcase
         end
      end
   end

   // request stage: memory read is issued alongside
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      if (accept) begin
         s1_in_range_ff <= idx_in_range;
         s1_addr_ff     <= idx_ext[ADDR_W-1:0];
         s1_command_ff  <= tst_pkg::command_type'(req_command);
         s1_syn_ff      <= req_syn_flag;
         s1_fin_ff      <= req_fin_flag;
         s1_rst_ff      <= req_rst_flag;
         s1_class_ff    <= tst_pkg::timer_class_type'(req_timer_class);
         s1_now_ff      <= req_now_ticks;
      end
   end

   tst_session_mem #(
      .DEPTH  (SESSIONS),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (idx_ext[ADDR_W-1:0]),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_data)
   );

   // entry written at the edge of this read arrives via the write-back register
   assign cur_entry = (wb_valid_ff && wb_addr_ff == s1_addr_ff) ? wb_data_ff : rd_data;
   assign cur_state = tst_pkg::tcp_state_type'(cur_entry[tst_pkg::ENTRY_W-1:tst_pkg::TICKS_W]);

   tst_transition u_trans (
      .command     (s1_command_ff),
      .cur_state   (cur_state),
      .syn_flag    (s1_syn_ff),
      .fin_flag    (s1_fin_ff),
      .rst_flag    (s1_rst_ff),
      .timer_class (s1_class_ff),
      .result      (trans)
   );

   always_comb begin
      if (trans.renew) begin
         new_deadline = s1_now_ff +
                        ((trans.renew_class == tst_pkg::CLS_TRANS) ? trans_ticks_ff : est_ticks_ff);
      end else begin
         new_deadline = cur_entry[tst_pkg::TICKS_W-1:0];
      end
   end

   assign wr_en   = s1_valid_ff && s1_in_range_ff;
   assign wr_data = {trans.next_state, new_deadline};

   always_ff @(posedge clock) begin
      if (reset) begin
         wb_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         wb_valid_ff   <= wr_en;
         rsp_strobe_ff <= s1_valid_ff;
      end
      wb_addr_ff <= s1_addr_ff;
      wb_data_ff <= wr_data;
      if (s1_valid_ff) begin
         if (s1_in_range_ff) begin
            rsp_state_ff    <= trans.next_state;
            rsp_renewed_ff  <= trans.renew;
            rsp_class_ff    <= trans.renew && (trans.renew_class == tst_pkg::CLS_TRANS);
            rsp_deadline_ff <= new_deadline;
            rsp_kept_ff     <= trans.kept;
         end else begin
            rsp_state_ff    <= '0;
            rsp_renewed_ff  <= 1'b0;
            rsp_class_ff    <= 1'b0;
            rsp_deadline_ff <= '0;
            rsp_kept_ff     <= 1'b0;
         end
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_new_state   = rsp_state_ff;
   assign rsp_renewed     = rsp_renewed_ff;
   assign rsp_renew_class = rsp_class_ff;
   assign rsp_deadline    = rsp_deadline_ff;
   assign rsp_kept        = rsp_kept_ff;

   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("request accepted without a response two cycles later");

   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("response without a matching request");

   a_kept_renews: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_kept) |->
         (rsp_new_state == tst_pkg::ST_FOUR_MIN && rsp_renewed && rsp_renew_class))
      else $error("kept session not renewed into four minute state");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

   localparam int TICKS = tst_pkg::TICKS_PER_SECOND_DEFAULT;
   localparam int POOL = 12;
   localparam int PHASES = 5;
   localparam int PHASE_REQS = 88;
   localparam int QUIET_MIN = 3;
   localparam int STALL_LIMIT = 2000;

   typedef enum int {W_REQ, W_CSR, W_QUIET} work_kind_type;

   typedef struct {
      work_kind_type                 kind;
      tst_pkg::command_type          cmd;
      logic [tst_pkg::INDEX_W-1:0]   idx;
      logic                          syn;
      logic                          fin;
      logic                          rst;
      logic                          cls;
      logic [tst_pkg::TICKS_W-1:0]   now;
      tst_pkg::csr_index_type        reg_sel;
      logic [tst_pkg::TIMEOUT_W-1:0] value;
   } work_type;

   typedef struct packed {
      tst_pkg::tcp_state_type        new_state;
      logic                          renewed;
      logic                          renew_class;
      logic [tst_pkg::TICKS_W-1:0]   deadline;
      logic                          kept;
   } session_outcome_type;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic [1:0]                    req_command;
   logic [tst_pkg::INDEX_W-1:0]   req_session_index;
   logic                          req_syn_flag;
   logic                          req_fin_flag;
   logic                          req_rst_flag;
   logic                          req_timer_class;
   logic [tst_pkg::TICKS_W-1:0]   req_now_ticks;
   logic                          rsp_strobe;
   logic [tst_pkg::STATE_W-1:0]   rsp_new_state;
   logic                          rsp_renewed;
   logic                          rsp_renew_class;
   logic [tst_pkg::TICKS_W-1:0]   rsp_deadline;
   logic                          rsp_kept;
   logic                          csr_write_enable;
   logic                          csr_index;
   logic [tst_pkg::TIMEOUT_W-1:0] csr_write_data;

   tcp_session_state_tracker DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_session_index (req_session_index),
      .req_syn_flag      (req_syn_flag),
      .req_fin_flag      (req_fin_flag),
      .req_rst_flag      (req_rst_flag),
      .req_timer_class   (req_timer_class),
      .req_now_ticks     (req_now_ticks),
      .rsp_strobe        (rsp_strobe),
      .rsp_new_state     (rsp_new_state),
      .rsp_renewed       (rsp_renewed),
      .rsp_renew_class   (rsp_renew_class),
      .rsp_deadline      (rsp_deadline),
      .rsp_kept          (rsp_kept),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   // shadow of the session table and timeout registers
   tst_pkg::tcp_state_type        sess_state [tst_pkg::SESSIONS_DEFAULT];
   logic [tst_pkg::TICKS_W-1:0]   sess_deadline [tst_pkg::SESSIONS_DEFAULT];
   logic [tst_pkg::TIMEOUT_W-1:0] est_timeout;
   logic [tst_pkg::TIMEOUT_W-1:0] trans_timeout;

   session_outcome_type           outcome_due [$];
   work_type                      work [$];

   // stimulus side bookkeeping
   bit                            made [tst_pkg::SESSIONS_DEFAULT];
   logic [tst_pkg::TICKS_W-1:0]   gen_now;
   int                            queued_reqs;

   bit                            holding;
   bit                            taken;
   int                            burst_left;
   int                            gap_left;
   int                            quiet_cycles;
   int                            stall_cycles;
   int                            faults;

   always #6 clock = ~clock;

   function automatic logic flip();
      return 1'($urandom_range(0, 1));
   endfunction

   function automatic tst_pkg::command_type pick_side();
      if ($urandom_range(0, 1) != 0)
         return tst_pkg::CMD_V4_PKT;
      return tst_pkg::CMD_V6_PKT;
   endfunction

   task automatic track_session(input tst_pkg::command_type cmd,
                                input logic [tst_pkg::INDEX_W-1:0] idx,
                                input logic syn, input logic fin, input logic rst,
                                input logic cls, input logic [tst_pkg::TICKS_W-1:0] now,
                                output session_outcome_type o);
      tst_pkg::tcp_state_type      st;
      tst_pkg::tcp_state_type      fin_to;
      logic                        ren;
      logic                        rcls;
      logic                        kp;
      logic [tst_pkg::TICKS_W-1:0] span;
      st = sess_state[idx];
      ren = 1'b0;
      rcls = tst_pkg::CLS_EST;
      kp = 1'b0;
      case (cmd)
         tst_pkg::CMD_CREATE: begin
            st = tst_pkg::ST_CLOSED;
            ren = 1'b1;
            rcls = cls;
         end
         tst_pkg::CMD_V4_PKT, tst_pkg::CMD_V6_PKT: begin
            if (cmd == tst_pkg::CMD_V4_PKT)
               fin_to = tst_pkg::ST_V4_FIN;
            else
               fin_to = tst_pkg::ST_V6_FIN;
            if (st == tst_pkg::ST_FOUR_MIN) begin
               if (!rst) begin
                  ren = 1'b1;
                  st = tst_pkg::ST_EST;
               end
            end else if (st == tst_pkg::ST_EST) begin
               if (fin) begin
                  st = fin_to;
               end else if (rst) begin
                  ren = 1'b1;
                  rcls = tst_pkg::CLS_TRANS;
                  st = tst_pkg::ST_FOUR_MIN;
               end else begin
                  ren = 1'b1;
               end
            end else if (cmd == tst_pkg::CMD_V4_PKT) begin
               case (st)
                  tst_pkg::ST_V6_SYN: if (syn) begin
                     ren = 1'b1;
                     st = tst_pkg::ST_EST;
                  end
                  tst_pkg::ST_V6_FIN: begin
                     ren = 1'b1;
                     if (fin) begin
                        rcls = tst_pkg::CLS_TRANS;
                        st = tst_pkg::ST_BOTH_FIN;
                     end
                  end
                  tst_pkg::ST_V4_FIN: ren = 1'b1;
                  default: ;
               endcase
            end else begin
               case (st)
                  tst_pkg::ST_CLOSED: if (syn) begin
                     ren = 1'b1;
                     rcls = tst_pkg::CLS_TRANS;
                     st = tst_pkg::ST_V6_SYN;
                  end
                  tst_pkg::ST_V6_SYN: if (syn) begin
                     ren = 1'b1;
                     rcls = tst_pkg::CLS_TRANS;
                  end
                  tst_pkg::ST_V4_SYN: if (syn) begin
                     ren = 1'b1;
                     st = tst_pkg::ST_EST;
                  end
                  tst_pkg::ST_V6_FIN: ren = 1'b1;
                  tst_pkg::ST_V4_FIN: begin
                     ren = 1'b1;
                     if (fin) begin
                        rcls = tst_pkg::CLS_TRANS;
                        st = tst_pkg::ST_BOTH_FIN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         default: begin
            if (st == tst_pkg::ST_EST) begin
               ren = 1'b1;
               rcls = tst_pkg::CLS_TRANS;
               st = tst_pkg::ST_FOUR_MIN;
               kp = 1'b1;
            end
         end
      endcase
      if (ren) begin
         span = 32'((rcls == tst_pkg::CLS_EST) ? est_timeout : trans_timeout) * 32'(TICKS);
         sess_deadline[idx] = now + span;
      end
      sess_state[idx] = st;
      o.new_state = st;
      o.renewed = ren;
      o.renew_class = ren ? rcls : 1'b0;
      o.deadline = sess_deadline[idx];
      o.kept = kp;
   endtask

   task automatic queue_req(input tst_pkg::command_type cmd,
                            input logic [tst_pkg::INDEX_W-1:0] idx,
                            input logic syn, input logic fin, input logic rst,
                            input logic cls);
      work_type w;
      w.kind = W_REQ;
      w.cmd = cmd;
      w.idx = idx;
      w.syn = syn;
      w.fin = fin;
      w.rst = rst;
      w.cls = cls;
      w.now = gen_now;
      w.reg_sel = tst_pkg::REG_EST_TIMEOUT;
      w.value = '0;
      work.push_back(w);
      if (cmd == tst_pkg::CMD_CREATE)
         made[idx] = 1'b1;
      queued_reqs++;
      if ($urandom_range(0, 19) == 0)
         gen_now = $urandom();
      else
         gen_now = gen_now + 32'($urandom_range(0, 3000));
   endtask

   task automatic queue_csr(input tst_pkg::csr_index_type sel,
                            input logic [tst_pkg::TIMEOUT_W-1:0] value);
      work_type w;
      w.kind = W_CSR;
      w.cmd = tst_pkg::CMD_CREATE;
      w.idx = '0;
      w.syn = 1'b0;
      w.fin = 1'b0;
      w.rst = 1'b0;
      w.cls = 1'b0;
      w.now = '0;
      w.reg_sel = sel;
      w.value = value;
      work.push_back(w);
   endtask

   task automatic queue_quiet();
      work_type w;
      w.kind = W_QUIET;
      w.cmd = tst_pkg::CMD_CREATE;
      w.idx = '0;
      w.syn = 1'b0;
      w.fin = 1'b0;
      w.rst = 1'b0;
      w.cls = 1'b0;
      w.now = '0;
      w.reg_sel = tst_pkg::REG_EST_TIMEOUT;
      w.value = '0;
      work.push_back(w);
   endtask

   // driver: presents requests and CSR writes, holds start until taken, idles between bursts
   always @(negedge clock) begin : drive
      work_type w;
      logic     go;
      logic     we;
      go = 1'b0;
      we = 1'b0;
      if (!reset) begin
         if (holding && taken) begin
            holding = 1'b0;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 90)
                                                        : $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            end
         end
         taken = 1'b0;
         if (holding) begin
            go = 1'b1;
         end else if (gap_left > 0) begin
            gap_left--;
         end else if (work.size() != 0) begin
            w = work[0];
            case (w.kind)
               W_REQ: begin
                  void'(work.pop_front());
                  req_command <= w.cmd;
                  req_session_index <= w.idx;
                  req_syn_flag <= w.syn;
                  req_fin_flag <= w.fin;
                  req_rst_flag <= w.rst;
                  req_timer_class <= w.cls;
                  req_now_ticks <= w.now;
                  holding = 1'b1;
                  go = 1'b1;
               end
               W_CSR: if (quiet_cycles >= QUIET_MIN && !busy) begin
                  void'(work.pop_front());
                  csr_index <= w.reg_sel;
                  csr_write_data <= w.value;
                  we = 1'b1;
               end
               default: if (quiet_cycles >= QUIET_MIN) begin
                  void'(work.pop_front());
               end
            endcase
         end
      end
      start <= go;
      csr_write_enable <= we;
   end

   // monitor: registers writes, predicts on acceptance, checks responses
   always @(posedge clock) begin : watch
      session_outcome_type want;
      bit                  moved;
      moved = 1'b0;
      if (!reset) begin
         if (csr_write_enable) begin
            moved = 1'b1;
            if (csr_index == tst_pkg::REG_EST_TIMEOUT)
               est_timeout = csr_write_data;
            else
               trans_timeout = csr_write_data;
         end
         if (start && !busy) begin
            moved = 1'b1;
            track_session(tst_pkg::command_type'(req_command), req_session_index,
                          req_syn_flag, req_fin_flag, req_rst_flag, req_timer_class,
                          req_now_ticks, want);
            outcome_due.push_back(want);
            taken = 1'b1;
         end
         if (rsp_strobe !== 1'b0) begin
            moved = 1'b1;
            if (outcome_due.size() == 0) begin
               faults++;
               if (faults <= 10)
                  $display("tb: response with no request pending: state %0d deadline %h",
                           rsp_new_state, rsp_deadline);
            end else begin
               want = outcome_due.pop_front();
               if (rsp_new_state !== want.new_state || rsp_renewed !== want.renewed ||
                   rsp_renew_class !== want.renew_class || rsp_deadline !== want.deadline ||
                   rsp_kept !== want.kept) begin
                  faults++;
                  if (faults <= 10)
                     $display({"tb: mismatch: state %0d/%0d renewed %b/%b class %b/%b ",
                               "deadline %h/%h kept %b/%b (expected/actual)"},
                              want.new_state, rsp_new_state, want.renewed, rsp_renewed,
                              want.renew_class, rsp_renew_class, want.deadline,
                              rsp_deadline, want.kept, rsp_kept);
               end
            end
         end
      end
      if (outcome_due.size() == 0 && !(start && !busy))
         quiet_cycles++;
      else
         quiet_cycles = 0;
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   initial begin : stimulus
      logic [tst_pkg::TIMEOUT_W-1:0] est_set [PHASES];
      logic [tst_pkg::TIMEOUT_W-1:0] trans_set [PHASES];
      logic [tst_pkg::INDEX_W-1:0]   pool [POOL];
      logic [tst_pkg::INDEX_W-1:0]   idx;
      tst_pkg::command_type          side_a;
      tst_pkg::command_type          side_b;
      int                            ph;
      int                            k;
      int                            n;
      int                            phase_end;
      bit                            paused;

      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_command = tst_pkg::CMD_CREATE;
      req_session_index = '0;
      req_syn_flag = 1'b0;
      req_fin_flag = 1'b0;
      req_rst_flag = 1'b0;
      req_timer_class = 1'b0;
      req_now_ticks = '0;
      csr_write_enable = 1'b0;
      csr_index = tst_pkg::REG_EST_TIMEOUT;
      csr_write_data = '0;
      est_timeout = tst_pkg::EST_TIMEOUT_RESET;
      trans_timeout = tst_pkg::TRANS_TIMEOUT_RESET;
      foreach (sess_state[i]) begin
         sess_state[i] = tst_pkg::ST_CLOSED;
         sess_deadline[i] = '0;
      end
      holding = 1'b0;
      taken = 1'b0;
      burst_left = 1;
      gap_left = 0;
      quiet_cycles = 0;
      stall_cycles = 0;
      faults = 0;
      queued_reqs = 0;

      // directed walk through the state machine at the reset timeouts
      gen_now = '0;
      queue_req(tst_pkg::CMD_CREATE, 10'd0, 1'b1, 1'b1, 1'b1, tst_pkg::CLS_EST);
      gen_now = 32'hFFFF_FFFF;  // deadline wraps past 2^32
      queue_req(tst_pkg::CMD_CREATE, 10'd1023, 1'b0, 1'b0, 1'b0, tst_pkg::CLS_TRANS);
      queue_req(tst_pkg::CMD_V4_PKT, 10'd0, 1'b1, 1'b1, 1'b1, 1'b0);   // v4 in closed: no effect
      queue_req(tst_pkg::CMD_V6_PKT, 10'd0, 1'b0, 1'b1, 1'b1, 1'b0);   // no syn: stays closed
      queue_req(tst_pkg::CMD_TIMEOUT, 10'd0, 1'b0, 1'b0, 1'b0, 1'b1);  // not kept
      queue_req(tst_pkg::CMD_V6_PKT, 10'd0, 1'b1, 1'b0, 1'b0, 1'b0);
      queue_req(tst_pkg::CMD_V6_PKT, 10'd0, 1'b1, 1'b0, 1'b0, 1'b0);
      queue_req(tst_pkg::CMD_V4_PKT, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0);
      queue_req(tst_pkg::CMD_V4_PKT, 10'd0, 1'b1, 1'b0, 1'b0, 1'b0);
      queue_req(tst_pkg::CMD_TIMEOUT, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0);  // kept
      queue_req(tst_pkg::CMD_V6_PKT, 10'd0, 1'b0, 1'b0, 1'b1, 1'b0);   // rst in four min
      queue_req(tst_pkg::CMD_V6_PKT, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0);
      queue_req(tst_pkg::CMD_V4_PKT, 10'd0, 1'b0, 1'b0, 1'b1, 1'b0);
      queue_req(tst_pkg::CMD_V4_PKT, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0);
      queue_req(tst_pkg::CMD_V4_PKT, 10'd0, 1'b0, 1'b1, 1'b1, 1'b0);
      queue_req(tst_pkg::CMD_V4_PKT, 10'd0, 1'b0, 1'b1, 1'b0, 1'b0);
      queue_req(tst_pkg::CMD_V6_PKT, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0);
      queue_req(tst_pkg::CMD_V6_PKT, 10'd0, 1'b0, 1'b1, 1'b0, 1'b0);
      queue_req(tst_pkg::CMD_V4_PKT, 10'd0, 1'b1, 1'b1, 1'b1, 1'b1);   // both fin: no effect
      queue_req(tst_pkg::CMD_V6_PKT, 10'd0, 1'b1, 1'b1, 1'b1, 1'b1);
      queue_req(tst_pkg::CMD_V6_PKT, 10'd1023, 1'b1, 1'b1, 1'b1, 1'b1);
      queue_req(tst_pkg::CMD_V4_PKT, 10'd1023, 1'b1, 1'b1, 1'b1, 1'b1);
      queue_req(tst_pkg::CMD_V6_PKT, 10'd1023, 1'b0, 1'b1, 1'b0, 1'b0);
      queue_req(tst_pkg::CMD_V6_PKT, 10'd1023, 1'b0, 1'b0, 1'b0, 1'b0);
      queue_req(tst_pkg::CMD_V4_PKT, 10'd1023, 1'b0, 1'b1, 1'b0, 1'b0);

      est_set = '{16'd0, 16'd65535, 16'd1, 16'($urandom), tst_pkg::EST_TIMEOUT_RESET};
      trans_set = '{16'd65535, 16'd0, 16'd1, 16'($urandom), tst_pkg::TRANS_TIMEOUT_RESET};

      for (ph = 0; ph < PHASES; ph++) begin
         queue_csr(tst_pkg::REG_EST_TIMEOUT, est_set[ph]);
         queue_csr(tst_pkg::REG_TRANS_TIMEOUT, trans_set[ph]);
         for (k = 0; k < POOL; k++) begin
            pool[k] = tst_pkg::INDEX_W'($urandom_range(0, tst_pkg::SESSIONS_DEFAULT - 1));
            if (!made[pool[k]])
               queue_req(tst_pkg::CMD_CREATE, pool[k], flip(), flip(), flip(), flip());
         end
         phase_end = queued_reqs + PHASE_REQS;
         paused = 1'b0;
         while (queued_reqs < phase_end) begin
            if (!paused && queued_reqs > phase_end - PHASE_REQS / 2) begin
               queue_quiet();
               paused = 1'b1;
            end
            idx = pool[$urandom_range(0, POOL - 1)];
            side_a = pick_side();
            if (side_a == tst_pkg::CMD_V4_PKT)
               side_b = tst_pkg::CMD_V6_PKT;
            else
               side_b = tst_pkg::CMD_V4_PKT;
            if ($urandom_range(0, 99) < 40) begin
               queue_req(tst_pkg::command_type'($urandom_range(0, 3)), idx, flip(), flip(),
                         flip(), flip());
            end else begin
               // open, exchange data, then close one of several ways
               queue_req(tst_pkg::CMD_CREATE, idx, flip(), flip(), flip(), flip());
               queue_req(tst_pkg::CMD_V6_PKT, idx, 1'b1, flip(), flip(), flip());
               if ($urandom_range(0, 3) == 0)
                  queue_req(tst_pkg::CMD_V6_PKT, idx, 1'b1, 1'b0, 1'b0, flip());
               queue_req(tst_pkg::CMD_V4_PKT, idx, 1'b1, flip(), flip(), flip());
               n = $urandom_range(0, 4);
               repeat (n)
                  queue_req(pick_side(), idx, flip(), 1'b0, 1'b0, flip());
               case ($urandom_range(0, 3))
                  0: begin
                     queue_req(side_a, idx, flip(), 1'b1, flip(), 1'b0);
                     repeat ($urandom_range(0, 2))
                        queue_req(pick_side(), idx, flip(), 1'b0, flip(), 1'b0);
                     queue_req(side_b, idx, flip(), 1'b1, flip(), 1'b0);
                  end
                  1: begin
                     queue_req(side_a, idx, flip(), 1'b0, 1'b1, 1'b0);
                     queue_req(side_b, idx, flip(), flip(), flip(), 1'b0);
                  end
                  2: begin
                     queue_req(tst_pkg::CMD_TIMEOUT, idx, flip(), flip(), flip(), flip());
                     queue_req(side_a, idx, flip(), flip(), flip(), 1'b0);
                  end
                  default: begin
                     queue_req(side_a, idx, 1'b0, 1'b1, 1'b0, 1'b0);
                     queue_req(side_a, idx, 1'b0, 1'b1, 1'b0, 1'b0);
                     queue_req(side_b, idx, 1'b0, 1'b1, 1'b0, 1'b0);
                     queue_req(side_b, idx, flip(), flip(), flip(), 1'b0);
                  end
               endcase
            end
         end
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (work.size() != 0 || holding)
         @(posedge clock);
      while (outcome_due.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
      faults += outcome_due.size();
      if (faults == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/tst_pkg.sv
hdl/tst_session_mem.sv
hdl/tst_transition.sv
hdl/tcp_session_state_tracker.sv
tb/sv/tb.sv
